>>> src/poly_voice_note_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the poly voice note engine
// Clocked on clk_i; the gated form is disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef POLY_VOICE_NOTE_ENGINE_ASSERT_SVH
`define POLY_VOICE_NOTE_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property checked only out of reset
`define PVNE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// property checked at every edge, reset included
`define PVNE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PVNE_ASSERT(lbl, prop, msg)
`define PVNE_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

>>> src/pvne_pkg.sv
// ----------------------------------------------------------------------------
// pvne_pkg
// Shared types and constants of the poly voice note engine.
// ----------------------------------------------------------------------------
package pvne_pkg;

  localparam int unsigned VOICES = 8;

  // item action codes
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  // upper status nibbles
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [2:0] {
    REG_STABILIZE_ON  = 3'd0,
    REG_SETTLE_TICKS  = 3'd1,
    REG_TRIG_DELAY    = 3'd2,
    REG_LOWEST_NOTE   = 3'd3,
    REG_HIGHEST_NOTE  = 3'd4,
    REG_PITCH_TOL     = 3'd5,
    REG_MIDI_CHANNEL  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic        stabilize_on;
    logic [9:0]  settle_ticks;
    logic [15:0] trigger_delay_ticks;
    logic [6:0]  lowest_note;
    logic [6:0]  highest_note;
    logic [7:0]  pitch_tolerance;
    logic [3:0]  midi_channel;
  } cfg_t;

  typedef struct packed {
    logic               action;
    logic [2:0]         voice;
    logic               gate;
    logic signed [15:0] pitch;
    logic [6:0]         velocity;
    logic               release_vel_given;
    logic [6:0]         release_velocity;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] status_byte;
    logic [6:0] note_number;
    logic [6:0] vel_byte;
  } result_t;

endpackage

>>> src/pvne_cfg.sv
// ----------------------------------------------------------------------------
// pvne_cfg
// APB-style configuration registers with their reset values.
// ----------------------------------------------------------------------------
module pvne_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvne_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output pvne_pkg::cfg_t                cfg_o
);
  import pvne_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx   = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STABILIZE_ON: cfg_d.stabilize_on        = pwdata[0];
        REG_SETTLE_TICKS: cfg_d.settle_ticks        = pwdata[9:0];
        REG_TRIG_DELAY:   cfg_d.trigger_delay_ticks = pwdata[15:0];
        REG_LOWEST_NOTE:  cfg_d.lowest_note         = pwdata[6:0];
        REG_HIGHEST_NOTE: cfg_d.highest_note        = pwdata[6:0];
        REG_PITCH_TOL:    cfg_d.pitch_tolerance     = pwdata[7:0];
        REG_MIDI_CHANNEL: cfg_d.midi_channel        = pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STABILIZE_ON: prdata = {31'd0, cfg_q.stabilize_on};
      REG_SETTLE_TICKS: prdata = {22'd0, cfg_q.settle_ticks};
      REG_TRIG_DELAY:   prdata = {16'd0, cfg_q.trigger_delay_ticks};
      REG_LOWEST_NOTE:  prdata = {25'd0, cfg_q.lowest_note};
      REG_HIGHEST_NOTE: prdata = {25'd0, cfg_q.highest_note};
      REG_PITCH_TOL:    prdata = {24'd0, cfg_q.pitch_tolerance};
      REG_MIDI_CHANNEL: prdata = {28'd0, cfg_q.midi_channel};
      default:          prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stabilize_on        <= 1'b1;
      cfg_q.settle_ticks        <= 10'd20;
      cfg_q.trigger_delay_ticks <= 16'd0;
      cfg_q.lowest_note         <= 7'd0;
      cfg_q.highest_note        <= 7'd127;
      cfg_q.pitch_tolerance     <= 8'd3;
      cfg_q.midi_channel        <= 4'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

>>> src/pvne_voice_bank.sv
// ----------------------------------------------------------------------------
// pvne_voice_bank
// Per-voice state and the combinational update that turns one registered
// word into at most one note message.
// ----------------------------------------------------------------------------
module pvne_voice_bank (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          proc_i,
  input  pvne_pkg::item_t               item_i,
  input  pvne_pkg::cfg_t                cfg_i,
  output pvne_pkg::result_t             res_o,
  output logic [pvne_pkg::VOICES-1:0]   sounding_o
);
  import pvne_pkg::*;

  logic [VOICES-1:0] gate_prev_q;
  logic [VOICES-1:0] pending_q;
  logic [VOICES-1:0] sounding_q;
  logic [VOICES-1:0] window_q;
  logic [15:0]        delay_q      [VOICES];
  logic [9:0]         stable_q     [VOICES];
  logic signed [15:0] held_pitch_q [VOICES];
  logic [6:0]         held_note_q  [VOICES];
  logic [6:0]         held_vel_q   [VOICES];

  logic               v_ok;
  logic               tick_wr;
  logic               rise;
  logic               pend_n, snd_n, win_n;
  logic [15:0]        dly_n;
  logic [9:0]         sc_n;
  logic signed [15:0] hp_n;
  logic               note_wr;
  logic signed [16:0] diff;
  logic [16:0]        adiff;
  logic [6:0]         note;
  logic               go;

  // round half away from zero to semitones, offset to note 24, clamp
  function automatic logic [6:0] pitch_to_note(logic signed [15:0] p);
    logic signed [17:0] pe;
    logic signed [17:0] st;
    logic signed [17:0] n;
    pe = 18'(p);
    if (!p[15]) st = (pe + 18'sd128) >>> 8;
    else        st = -((18'sd128 - pe) >>> 8);
    n = st + 18'sd24;
    if (n < 18'sd0)   n = 18'sd0;
    if (n > 18'sd127) n = 18'sd127;
    return n[6:0];
  endfunction

  assign v_ok    = (32'(item_i.voice) < VOICES);
  assign tick_wr = proc_i && (item_i.action == ACT_TICK) && v_ok;
  assign note    = pitch_to_note(item_i.pitch);
  assign diff    = 17'(item_i.pitch) - 17'(held_pitch_q[item_i.voice]);
  assign adiff   = diff[16] ? 17'(-diff) : 17'(diff);
  assign sounding_o = sounding_q;

  always_comb begin
    rise   = item_i.gate & ~gate_prev_q[item_i.voice];
    pend_n = rise | pending_q[item_i.voice];
    win_n  = ~rise & window_q[item_i.voice];
    dly_n  = rise ? cfg_i.trigger_delay_ticks : delay_q[item_i.voice];
    snd_n  = sounding_q[item_i.voice];
    sc_n   = stable_q[item_i.voice];
    hp_n   = held_pitch_q[item_i.voice];
    note_wr = 1'b0;
    go     = 1'b0;
    res_o  = '0;

    if (!item_i.gate) begin
      pend_n = 1'b0;
      if (snd_n) begin
        snd_n             = 1'b0;
        res_o.valid       = 1'b1;
        res_o.status_byte = {STAT_NOTE_OFF, cfg_i.midi_channel};
        res_o.note_number = held_note_q[item_i.voice];
        res_o.vel_byte    = item_i.release_vel_given ? item_i.release_velocity
                                                     : held_vel_q[item_i.voice];
      end
    end else if (pend_n) begin
      go = 1'b1;
      if (!win_n) begin
        if (dly_n != 16'd0) begin
          dly_n = dly_n - 16'd1;
          go    = 1'b0;
        end else begin
          win_n = 1'b1;
          hp_n  = item_i.pitch;
          sc_n  = 10'd0;
        end
      end else if (adiff > 17'(cfg_i.pitch_tolerance)) begin
        hp_n = item_i.pitch;
        sc_n = 10'd0;
      end else if (sc_n != '1) begin
        sc_n = sc_n + 10'd1;
      end

      if (go && (!cfg_i.stabilize_on || sc_n >= cfg_i.settle_ticks)) begin
        pend_n = 1'b0;
        if (note >= cfg_i.lowest_note && note <= cfg_i.highest_note) begin
          note_wr           = 1'b1;
          snd_n             = 1'b1;
          res_o.valid       = 1'b1;
          res_o.status_byte = {STAT_NOTE_ON, cfg_i.midi_channel};
          res_o.note_number = note;
          res_o.vel_byte    = item_i.velocity;
        end
      end
    end

    if (!tick_wr) res_o.valid = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_prev_q <= '0;
      pending_q   <= '0;
      sounding_q  <= '0;
      window_q    <= '0;
    end else if (proc_i && item_i.action == ACT_CLEAR) begin
      pending_q  <= '0;
      sounding_q <= '0;
    end else if (tick_wr) begin
      gate_prev_q[item_i.voice] <= item_i.gate;
      pending_q[item_i.voice]   <= pend_n;
      sounding_q[item_i.voice]  <= snd_n;
      window_q[item_i.voice]    <= win_n;
    end
  end

  // data fields are only read after the flags above say they were written
  always_ff @(posedge clk_i) begin
    if (tick_wr) begin
      delay_q[item_i.voice]      <= dly_n;
      stable_q[item_i.voice]     <= sc_n;
      held_pitch_q[item_i.voice] <= hp_n;
      if (note_wr) begin
        held_note_q[item_i.voice] <= note;
        held_vel_q[item_i.voice]  <= item_i.velocity;
      end
    end
  end

endmodule

>>> src/poly_voice_note_engine.sv
// ----------------------------------------------------------------------------
// poly_voice_note_engine
// Per-voice gate and pitch ticks in, MIDI note-on / note-off words out.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in       to block   in_valid_i / in_ready_o      action, voice, gate, pitch,
//                                                   velocity, release velocity
//  out      from block out_valid_o / out_ready_i    status_byte, note_number,
//                                                   vel_byte
//  cfg      to block   psel, penable, pwrite, pready  paddr, pwdata, prdata
//
//  One word per cycle sustained while the output is not stalled; a word is
//  registered at acceptance and its result, if it yields one, is registered
//  once the voice-state update runs on it (out_valid_o rises as it loads).
//  The rate is set by the single voice-state update between input and
//  output registers.
//  Reset clears all voice flags at once; no clearing pass is needed.
//  A stalled output holds the update; the input register takes one more word.
// ----------------------------------------------------------------------------
module poly_voice_note_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [2:0]                    voice_i,
  input  logic                          gate_i,
  input  logic signed [15:0]            pitch_i,
  input  logic [6:0]                    velocity_i,
  input  logic                          release_vel_given_i,
  input  logic [6:0]                    release_velocity_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    status_byte_o,
  output logic [6:0]                    note_number_o,
  output logic [6:0]                    vel_byte_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pvne_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import pvne_pkg::*;

  cfg_t              cfg;
  item_t             item_q;
  logic              in_vld_q, in_vld_d;
  logic              out_vld_q, out_vld_d;
  result_t           res;
  result_t           res_q;
  logic              proc;
  logic              in_acc;
  logic [VOICES-1:0] sounding;

  pvne_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pvne_voice_bank u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .proc_i     (proc),
    .item_i     (item_q),
    .cfg_i      (cfg),
    .res_o      (res),
    .sounding_o (sounding)
  );

  // advance the held word only when the output slot is free or draining
  assign proc       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_vld_d   = in_acc || (in_vld_q && !proc);
  assign out_vld_d  = proc ? res.valid : (out_vld_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q.action            <= action_i;
      item_q.voice             <= voice_i;
      item_q.gate              <= gate_i;
      item_q.pitch             <= pitch_i;
      item_q.velocity          <= velocity_i;
      item_q.release_vel_given <= release_vel_given_i;
      item_q.release_velocity  <= release_velocity_i;
    end
    if (proc && res.valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign status_byte_o = res_q.status_byte;
  assign note_number_o = res_q.note_number;
  assign vel_byte_o    = res_q.vel_byte;

`include "poly_voice_note_engine_assert.svh"

  `PVNE_ASSERT(a_hold_word, (in_vld_q && out_vld_q && !out_ready_i) |=> in_vld_q, "held word lost under output stall")
  `PVNE_ASSERT(a_status_kind, out_vld_q |-> (res_q.status_byte[7:4] == STAT_NOTE_OFF || res_q.status_byte[7:4] == STAT_NOTE_ON), "bad status nibble")
  `PVNE_ASSERT(a_clear_all, (proc && item_q.action == ACT_CLEAR) |=> (sounding == '0), "voice still sounding after clear")
  `PVNE_ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> (!out_valid_o && in_ready_o), "not idle after reset")

endmodule
